@@ rtl/lottp_pkg.sv @@
package lottp_pkg;

    localparam int ENTRIES     = 16;
    localparam int TICKET_BITS = 12;

    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int TOTAL_W  = 16;
    localparam int THREAD_W = 4;
    localparam int ACTIVE_W = 5;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_FINISH = 2'd1;
    localparam logic [1:0] ACT_PICK   = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] OUT_OK        = 2'd0;
    localparam logic [1:0] OUT_FULL      = 2'd1;
    localparam logic [1:0] OUT_NO_ACTIVE = 2'd2;
    localparam logic [1:0] OUT_ZERO_TKT  = 2'd3;

    localparam logic [TOTAL_W-1:0] LFSR_POLY  = 16'hB400;
    localparam logic [TOTAL_W-1:0] DRAW_LIMIT = 16'hFFFF;

    typedef struct packed {
        logic               high_en;
        logic               done_en;
        logic [IDX_W-1:0]   addr;
        logic [TOTAL_W-1:0] high;
        logic               done;
    } t_tbl_wr;

    function automatic logic [TOTAL_W-1:0] lfsr_step(input logic [TOTAL_W-1:0] v);
        logic [TOTAL_W-1:0] n;
        n = v >> 1;
        if (v[0]) begin
            n = n ^ LFSR_POLY;
        end
        if (n == '0) begin
            n = TOTAL_W'(1);
        end
        return n;
    endfunction

endpackage

@@ rtl/lottp_mod_unit.sv @@
module lottp_mod_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lottp_pkg::TOTAL_W-1:0] i_dividend,
    input  logic [lottp_pkg::TOTAL_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [lottp_pkg::TOTAL_W-1:0] o_rem
);
    import lottp_pkg::*;

    localparam int STEP_W = $clog2(TOTAL_W);

    logic               r_busy;
    logic [STEP_W-1:0]  r_cnt;
    logic [TOTAL_W-1:0] r_dvd;
    logic [TOTAL_W-1:0] r_div;
    logic [TOTAL_W-1:0] r_rem;
    logic               r_done;
    logic [TOTAL_W:0]   trial;
    logic [TOTAL_W:0]   diff;
    logic [TOTAL_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[TOTAL_W-1]};
        diff  = trial - {1'b0, r_div};
        if (!diff[TOTAL_W]) begin
            n_rem = diff[TOTAL_W-1:0];
        end else begin
            n_rem = trial[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(TOTAL_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ rtl/lottp_table.sv @@
module lottp_table (
    input  logic                          i_clk,
    input  lottp_pkg::t_tbl_wr            i_wr,
    input  logic [lottp_pkg::IDX_W-1:0]   i_rd_addr,
    output logic [lottp_pkg::TOTAL_W-1:0] o_rd_high,
    output logic                          o_rd_done
);
    import lottp_pkg::*;

    logic [TOTAL_W-1:0] high_mem [ENTRIES];
    logic               done_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr.high_en) begin
            high_mem[i_wr.addr] <= i_wr.high;
        end
        o_rd_high <= high_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.done_en) begin
            done_mem[i_wr.addr] <= i_wr.done;
        end
        o_rd_done <= done_mem[i_rd_addr];
    end

endmodule

@@ rtl/lottery_thread_picker_unit.sv @@
// Channel   | Handshake        | Ports
// ----------+------------------+----------------------------------------------
// item in   | start && !busy   | i_action, i_ticket_count
// result    | o_strobe (1 cyc) | o_thread_index, o_outcome, o_active_count
// seed cfg  | i_cfg_we         | i_cfg_data
//
// Add, finish and clear give their result in the cycle after the item is taken.
// A pick draws a new random number, reduces it modulo the ticket total in the serial
// modulo unit, then scans the table one entry at a time, reading and then comparing,
// until it finds the entry the draw lands in; a finished entry starts a new draw.
// Reset is synchronous and active low and loads the random generator with 1.
// The result strobe cannot be held off, so busy depends only on the sequencer.
module lottery_thread_picker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [11:0] i_ticket_count,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic [3:0]  o_thread_index,
    output logic [1:0]  o_outcome,
    output logic [4:0]  o_active_count
);
    import lottp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DRAW = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;

    logic [2:0]         r_state;
    logic [CNT_W-1:0]   r_created;
    logic [CNT_W-1:0]   r_live;
    logic [TOTAL_W-1:0] r_total;
    logic [IDX_W-1:0]   r_run_idx;
    logic               r_run_valid;
    logic [TOTAL_W-1:0] r_lfsr;
    logic [TOTAL_W-1:0] r_tries;
    logic [IDX_W-1:0]   r_idx;
    logic               r_strobe;
    logic [THREAD_W-1:0] r_thread;
    logic [1:0]         r_outcome;
    logic [ACTIVE_W-1:0] r_active;

    logic               accept;
    logic [TOTAL_W-1:0] tickets;
    logic [TOTAL_W:0]   sum;
    logic               add_full;
    logic               add_ok;
    logic               fin_ok;
    logic [TOTAL_W-1:0] n_lfsr;
    logic               mod_start;
    logic               mod_done;
    logic [TOTAL_W-1:0] mod_rem;
    t_tbl_wr            tbl_wr;
    logic [TOTAL_W-1:0] rd_high;
    logic               rd_done;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign tickets  = TOTAL_W'(i_ticket_count[TICKET_BITS-1:0]);
    assign sum      = {1'b0, r_total} + {1'b0, tickets};
    assign add_full = (r_created >= CNT_W'(ENTRIES)) || sum[TOTAL_W];
    assign add_ok   = accept && (i_action == ACT_ADD) && !add_full && (tickets != '0);
    assign fin_ok   = accept && (i_action == ACT_FINISH) && r_run_valid;
    assign n_lfsr   = lfsr_step(r_lfsr);
    assign mod_start = (r_state == S_DRAW);

    always_comb begin
        tbl_wr = '0;
        if (add_ok) begin
            tbl_wr.high_en = 1'b1;
            tbl_wr.done_en = 1'b1;
            tbl_wr.addr    = r_created[IDX_W-1:0];
            tbl_wr.high    = sum[TOTAL_W-1:0];
            tbl_wr.done    = 1'b0;
        end else if (fin_ok) begin
            tbl_wr.done_en = 1'b1;
            tbl_wr.addr    = r_run_idx;
            tbl_wr.done    = 1'b1;
        end
    end

    lottp_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (n_lfsr),
        .i_divisor  (r_total),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    lottp_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_addr (r_idx),
        .o_rd_high (rd_high),
        .o_rd_done (rd_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_created   <= '0;
            r_live      <= '0;
            r_total     <= '0;
            r_run_idx   <= '0;
            r_run_valid <= 1'b0;
            r_lfsr      <= TOTAL_W'(1);
            r_tries     <= '0;
            r_idx       <= '0;
            r_strobe    <= 1'b0;
            r_thread    <= '0;
            r_outcome   <= OUT_OK;
            r_active    <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_thread  <= '0;
                        r_outcome <= OUT_OK;
                        r_active  <= ACTIVE_W'(r_live);
                        case (i_action)
                            ACT_ADD: begin
                                r_strobe <= 1'b1;
                                if (add_full) begin
                                    r_outcome <= OUT_FULL;
                                end else if (tickets == '0) begin
                                    r_outcome <= OUT_ZERO_TKT;
                                end else begin
                                    r_thread  <= THREAD_W'(r_created);
                                    r_created <= r_created + CNT_W'(1);
                                    r_live    <= r_live + CNT_W'(1);
                                    r_active  <= ACTIVE_W'(r_live + CNT_W'(1));
                                    r_total   <= sum[TOTAL_W-1:0];
                                end
                            end
                            ACT_FINISH: begin
                                r_strobe <= 1'b1;
                                if (r_run_valid) begin
                                    r_run_valid <= 1'b0;
                                    if (r_live != '0) begin
                                        r_live   <= r_live - CNT_W'(1);
                                        r_active <= ACTIVE_W'(r_live - CNT_W'(1));
                                    end
                                end else begin
                                    r_outcome <= OUT_NO_ACTIVE;
                                end
                            end
                            ACT_PICK: begin
                                if (r_live == '0 || r_total == '0) begin
                                    r_strobe  <= 1'b1;
                                    r_outcome <= OUT_NO_ACTIVE;
                                end else begin
                                    r_tries <= '0;
                                    r_state <= S_DRAW;
                                end
                            end
                            default: begin
                                r_strobe    <= 1'b1;
                                r_created   <= '0;
                                r_live      <= '0;
                                r_total     <= '0;
                                r_run_idx   <= '0;
                                r_run_valid <= 1'b0;
                                r_active    <= '0;
                            end
                        endcase
                    end
                end
                S_DRAW: begin
                    r_lfsr  <= n_lfsr;
                    r_tries <= r_tries + TOTAL_W'(1);
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_idx   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (mod_rem < rd_high) begin
                        if (!rd_done) begin
                            r_run_idx   <= r_idx;
                            r_run_valid <= 1'b1;
                            r_strobe    <= 1'b1;
                            r_thread    <= THREAD_W'(r_idx);
                            r_outcome   <= OUT_OK;
                            r_active    <= ACTIVE_W'(r_live);
                            r_state     <= S_IDLE;
                        end else if (r_tries == DRAW_LIMIT) begin
                            r_strobe  <= 1'b1;
                            r_thread  <= '0;
                            r_outcome <= OUT_NO_ACTIVE;
                            r_active  <= ACTIVE_W'(r_live);
                            r_state   <= S_IDLE;
                        end else begin
                            r_state <= S_DRAW;
                        end
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                r_lfsr <= (i_cfg_data != '0) ? i_cfg_data : TOTAL_W'(1);
            end
        end
    end

    assign o_strobe       = r_strobe;
    assign o_thread_index = r_thread;
    assign o_outcome      = r_outcome;
    assign o_active_count = r_active;

endmodule

@@ tb/lottery_schedule_checker.sv @@
`timescale 1ns / 100ps

module lottery_schedule_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [1:0]          i_action,
    input  logic [11:0]         i_ticket_count,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data,
    input  logic                o_strobe,
    input  logic [3:0]          o_thread_index,
    input  logic [1:0]          o_outcome,
    input  logic [4:0]          o_active_count,
    output int                  fail_count,
    output int                  pending
);
    import lottp_pkg::*;

    typedef enum logic [1:0] {
        TH_DONE    = 2'd0,
        TH_READY   = 2'd1,
        TH_RUNNING = 2'd2
    } t_thread_state;

    typedef struct packed {
        logic [THREAD_W-1:0] thread_index;
        logic [1:0]          outcome;
        logic [ACTIVE_W-1:0] active_count;
    } t_sched_result;

    logic [TOTAL_W-1:0] tkt_low  [ENTRIES];
    logic [TOTAL_W-1:0] tkt_high [ENTRIES];
    t_thread_state      thr_state[ENTRIES];
    int                 n_created;
    int                 n_live;
    int                 tkt_total;
    int                 run_idx;
    bit                 run_valid;
    logic [TOTAL_W-1:0] lfsr_q = 16'd1;

    t_sched_result      sched_expected_q[$];
    int                 mismatch_total = 0;
    int                 queued_results = 0;

    assign fail_count = mismatch_total;
    assign pending    = queued_results;

    function automatic logic [TOTAL_W-1:0] advance_lfsr(input logic [TOTAL_W-1:0] v);
        logic [TOTAL_W-1:0] n;
        n = {1'b0, v[TOTAL_W-1:1]};
        if (v[0]) begin
            n = n ^ LFSR_POLY;
        end
        if (n == '0) begin
            n = 16'd1;
        end
        return n;
    endfunction

    function automatic void clear_table();
        n_created = 0;
        n_live    = 0;
        tkt_total = 0;
        run_idx   = 0;
        run_valid = 1'b0;
    endfunction

    function automatic t_sched_result predict_schedule(input logic [1:0] act,
                                                       input logic [11:0] tk);
        t_sched_result r;
        int tickets;
        int draw;
        int chosen;
        int tries;
        bit found;
        r = '0;
        tickets = int'(tk) & ((1 << TICKET_BITS) - 1);
        case (act)
            ACT_ADD: begin
                if (n_created >= ENTRIES || tkt_total + tickets > 65535) begin
                    r.outcome = OUT_FULL;
                end else if (tickets == 0) begin
                    r.outcome = OUT_ZERO_TKT;
                end else begin
                    tkt_low[n_created]   = TOTAL_W'(tkt_total);
                    tkt_high[n_created]  = TOTAL_W'(tkt_total + tickets);
                    thr_state[n_created] = TH_READY;
                    r.thread_index = THREAD_W'(n_created);
                    n_created++;
                    n_live++;
                    tkt_total += tickets;
                end
            end
            ACT_FINISH: begin
                if (run_valid && thr_state[run_idx] == TH_RUNNING) begin
                    thr_state[run_idx] = TH_DONE;
                    if (n_live > 0) begin
                        n_live--;
                    end
                    run_valid = 1'b0;
                end else begin
                    r.outcome = OUT_NO_ACTIVE;
                end
            end
            ACT_PICK: begin
                if (n_live == 0 || tkt_total == 0) begin
                    r.outcome = OUT_NO_ACTIVE;
                end else begin
                    found  = 1'b0;
                    chosen = 0;
                    for (tries = 0; tries < int'(DRAW_LIMIT) && !found; tries++) begin
                        lfsr_q = advance_lfsr(lfsr_q);
                        draw = int'(lfsr_q) % tkt_total;
                        for (int i = 0; i < n_created; i++) begin
                            if (draw >= int'(tkt_low[i]) && draw < int'(tkt_high[i]) &&
                                thr_state[i] != TH_DONE) begin
                                chosen = i;
                                found  = 1'b1;
                            end
                        end
                    end
                    if (!found) begin
                        r.outcome = OUT_NO_ACTIVE;
                    end else begin
                        if (run_valid && thr_state[run_idx] == TH_RUNNING) begin
                            thr_state[run_idx] = TH_READY;
                        end
                        thr_state[chosen] = TH_RUNNING;
                        run_idx   = chosen;
                        run_valid = 1'b1;
                        r.thread_index = THREAD_W'(chosen);
                    end
                end
            end
            default: begin
                clear_table();
            end
        endcase
        r.active_count = ACTIVE_W'(n_live);
        return r;
    endfunction

    function automatic int check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s differs: expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_sched_result want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            clear_table();
            lfsr_q = 16'd1;
            sched_expected_q.delete();
        end else begin
            if (o_strobe) begin
                if (sched_expected_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                             $time, o_thread_index, o_outcome, o_active_count);
                    errs++;
                end else begin
                    want = sched_expected_q.pop_front();
                    errs += check_field("thread_index", int'(want.thread_index),
                                        int'(o_thread_index));
                    errs += check_field("outcome", int'(want.outcome), int'(o_outcome));
                    errs += check_field("active_count", int'(want.active_count),
                                        int'(o_active_count));
                end
            end
            if (i_cfg_we) begin
                lfsr_q = (i_cfg_data == '0) ? 16'd1 : i_cfg_data;
            end
            if (start && !busy) begin
                sched_expected_q.push_back(predict_schedule(i_action, i_ticket_count));
            end
        end
        mismatch_total <= mismatch_total + errs;
        queued_results <= sched_expected_q.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import lottp_pkg::*;

    localparam int CYCLE_LIMIT = 8_000_000;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic [1:0]  i_action       = '0;
    logic [11:0] i_ticket_count = '0;
    logic        i_cfg_we       = 1'b0;
    logic [15:0] i_cfg_data     = '0;
    logic        busy;
    logic        o_strobe;
    logic [3:0]  o_thread_index;
    logic [1:0]  o_outcome;
    logic [4:0]  o_active_count;

    int fail_count;
    int pending;
    int cycles   = 0;
    int items    = 0;
    int added    = 0;
    int finishes = 0;
    bit gaps_on  = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lottery_thread_picker_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_ticket_count (i_ticket_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_thread_index (o_thread_index),
        .o_outcome      (o_outcome),
        .o_active_count (o_active_count)
    );

    lottery_schedule_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_ticket_count (i_ticket_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_thread_index (o_thread_index),
        .o_outcome      (o_outcome),
        .o_active_count (o_active_count),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [11:0] tickets_at(input int scale);
        return 12'($urandom_range((1 << scale) - 1, 1 << (scale - 1)));
    endfunction

    // Finishes are capped so the live share of the tickets stays large and picks stay short.
    function automatic bit finish_allowed();
        return (finishes * 2 < added) || (added == 1 && finishes == 0);
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [11:0] tk);
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= act;
        i_ticket_count <= tk;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items++;
        if (act == ACT_CLEAR) begin
            added    = 0;
            finishes = 0;
        end else if (act == ACT_ADD && tk != '0 && added < ENTRIES) begin
            added++;
        end else if (act == ACT_FINISH) begin
            finishes++;
        end
    endtask

    task automatic write_seed(input logic [15:0] seed);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= seed;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_round(input bit last_part);
        int scale;
        int nadd;
        int nops;
        int choice;
        logic [1:0] act;
        logic [11:0] tk;
        gaps_on = last_part ? 1'b0 : ($urandom_range(0, 2) != 0);
        send_item(ACT_CLEAR, 12'($urandom));
        scale = $urandom_range(1, 12);
        nadd  = $urandom_range(1, ENTRIES + 2);
        repeat (nadd) begin
            send_item(ACT_ADD, ($urandom_range(0, 11) == 0) ? 12'd0 : tickets_at(scale));
        end
        nops = $urandom_range(4, 24);
        repeat (nops) begin
            choice = $urandom_range(0, 9);
            tk = 12'($urandom);
            if (choice <= 5) begin
                act = ACT_PICK;
            end else if (choice <= 7) begin
                act = ACT_FINISH;
            end else if (choice == 8) begin
                act = ACT_ADD;
                tk  = tickets_at(scale);
            end else begin
                act = 2'($urandom_range(0, 3));
                if (act == ACT_ADD) begin
                    tk = ($urandom_range(0, 3) == 0) ? 12'd0 : tickets_at(scale);
                end
            end
            if (act == ACT_FINISH && !finish_allowed()) begin
                act = ACT_PICK;
            end
            send_item(act, tk);
        end
    endtask

    initial begin
        logic [15:0] seed;
        int target;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gaps_on = 1'b1;
        send_item(ACT_PICK, 12'hFFF);
        send_item(ACT_FINISH, 12'h000);
        send_item(ACT_ADD, 12'h000);
        send_item(ACT_ADD, 12'h001);
        send_item(ACT_ADD, 12'hFFF);
        send_item(ACT_PICK, 12'h000);
        send_item(ACT_FINISH, 12'hAAA);
        send_item(ACT_FINISH, 12'h555);
        send_item(ACT_PICK, 12'h000);
        send_item(ACT_CLEAR, 12'h000);
        send_item(ACT_FINISH, 12'h000);
        send_item(ACT_PICK, 12'h000);
        for (int i = 0; i < ENTRIES; i++) begin
            send_item(ACT_ADD, (i % 2 == 1) ? 12'hAAA : 12'hFFF);
        end
        send_item(ACT_ADD, 12'hFFF);
        send_item(ACT_ADD, 12'h000);

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    seed = 16'h0000;
                end
                1: begin
                    seed = 16'hFFFF;
                end
                2: begin
                    seed = 16'h0001;
                end
                default: begin
                    seed = 16'($urandom_range(1, 65535));
                end
            endcase
            write_seed(seed);
            target = items + 85;
            while (items < target) run_round(ph == 6);
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ lottery_thread_picker_unit.f @@
rtl/lottp_pkg.sv
rtl/lottp_mod_unit.sv
rtl/lottp_table.sv
rtl/lottery_thread_picker_unit.sv
tb/lottery_schedule_checker.sv
tb/testbench.sv
